[rtl/path_command_interpreter_core_assert.svh]
// Assertion macros shared by the path command interpreter RTL.
`ifndef PATH_COMMAND_INTERPRETER_CORE_ASSERT_SVH
`define PATH_COMMAND_INTERPRETER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PCI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pci same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PCI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pci next-cycle check failed");

`endif

[rtl/pci_pkg.sv]
// Shared types and codes of the path command interpreter.
package pci_pkg;

  // Path commands
  typedef enum logic [2:0] {
    CMD_MOVE      = 3'd0,
    CMD_LINE      = 3'd1,
    CMD_CURVE     = 3'd2,
    CMD_REL_MOVE  = 3'd3,
    CMD_REL_LINE  = 3'd4,
    CMD_REL_CURVE = 3'd5,
    CMD_CLOSE     = 3'd6,
    CMD_END_PATH  = 3'd7
  } cmd_t;

  // Emitted event kinds
  typedef enum logic [2:0] {
    EV_EDGE   = 3'd0,
    EV_SPLINE = 3'd1,
    EV_CAP    = 3'd2,
    EV_JOIN   = 3'd3,
    EV_PATH   = 3'd4
  } ev_kind_t;

  localparam int OUT_COORD_W = 32;

  // One result event
  typedef struct packed {
    ev_kind_t                 kind;
    logic [OUT_COORD_W-1:0]   a_x;
    logic [OUT_COORD_W-1:0]   a_y;
    logic [OUT_COORD_W-1:0]   b_x;
    logic [OUT_COORD_W-1:0]   b_y;
    logic [OUT_COORD_W-1:0]   c_x;
    logic [OUT_COORD_W-1:0]   c_y;
    logic [OUT_COORD_W-1:0]   d_x;
    logic [OUT_COORD_W-1:0]   d_y;
    logic                     last;
  } event_t;

  // Events caused by one command (count is 0, 1 or 2)
  typedef struct packed {
    logic [1:0] count;
    event_t     ev0;
    event_t     ev1;
  } ev_pair_t;

  // Status of the output stage
  typedef struct packed {
    logic can_load;
    logic pend_valid;
  } out_ctl_t;

endpackage

[rtl/path_command_interpreter_core.sv]
// Path command interpreter top level: input register, path state, decode, output stage.
// A command's first event goes through the input register, then the output register.
// Throughput: one command per cycle unless the output stalls; close and end path with
// an open edge hold their second event in the hold slot, which blocks further decode.
// Commands that emit nothing are consumed in their decode cycle.
// Reset (rst, synchronous): clears valid flags, current and start points and edge flags.
module path_command_interpreter_core #(
  parameter int COORD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y
  input  logic [7:0]   s_tuser,   // command[2:0], zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [255:0] m_tdata,   // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
  output logic [7:0]   m_tuser,   // event_kind[2:0], zero pad
  output logic         m_tlast    // last
);

  logic                in_valid;
  pci_pkg::cmd_t       in_cmd;
  logic signed [31:0]  in_p0_x, in_p0_y, in_p1_x, in_p1_y, in_p2_x, in_p2_y;
  logic                advance;

  logic [COORD_BITS-1:0] current_x, current_y, start_x, start_y;
  logic                  have_point, have_edge;
  logic [COORD_BITS-1:0] current_x_next, current_y_next, start_x_next, start_y_next;
  logic                  have_point_next, have_edge_next;

  pci_pkg::ev_pair_t events;
  pci_pkg::out_ctl_t out_ctl;

  // Decode a held command when the output stage can take its events
  assign advance  = in_valid && out_ctl.can_load;
  assign s_tready = !in_valid || advance;

  // Hold the input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= pci_pkg::cmd_t'(s_tuser[2:0]);
      in_p0_x <= s_tdata[31:0];
      in_p0_y <= s_tdata[63:32];
      in_p1_x <= s_tdata[95:64];
      in_p1_y <= s_tdata[127:96];
      in_p2_x <= s_tdata[159:128];
      in_p2_y <= s_tdata[191:160];
    end
  end

  // Advance path state on each decoded command
  always_ff @(posedge clk) begin
    if (rst) begin
      current_x  <= '0;
      current_y  <= '0;
      start_x    <= '0;
      start_y    <= '0;
      have_point <= 1'b0;
      have_edge  <= 1'b0;
    end else if (advance) begin
      current_x  <= current_x_next;
      current_y  <= current_y_next;
      start_x    <= start_x_next;
      start_y    <= start_y_next;
      have_point <= have_point_next;
      have_edge  <= have_edge_next;
    end
  end

  pci_decode #(
    .COORD_BITS(COORD_BITS)
  ) u_decode (
    .cmd             (in_cmd),
    .p0_x            (in_p0_x),
    .p0_y            (in_p0_y),
    .p1_x            (in_p1_x),
    .p1_y            (in_p1_y),
    .p2_x            (in_p2_x),
    .p2_y            (in_p2_y),
    .current_x       (current_x),
    .current_y       (current_y),
    .start_x         (start_x),
    .start_y         (start_y),
    .have_point      (have_point),
    .have_edge       (have_edge),
    .current_x_next  (current_x_next),
    .current_y_next  (current_y_next),
    .start_x_next    (start_x_next),
    .start_y_next    (start_y_next),
    .have_point_next (have_point_next),
    .have_edge_next  (have_edge_next),
    .events          (events)
  );

  pci_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .events   (events),
    .ctl      (out_ctl),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Checks
`include "path_command_interpreter_core_assert.svh"

  `PCI_ASSERT_NOW(a_pend_shown, clk, rst, out_ctl.pend_valid, m_tvalid)
  `PCI_ASSERT_NOW(a_pend_not_last, clk, rst, out_ctl.pend_valid, !m_tlast)
  `PCI_ASSERT_NOW(a_edge_needs_point, clk, rst, have_edge, have_point)
  `PCI_ASSERT_NOW(a_held_blocks_input, clk, rst, in_valid && !advance, !s_tready)

endmodule

[rtl/pci_decode.sv]
// Command decode: relative offset, event build and next path state.
module pci_decode #(
  parameter int COORD_BITS = 32
) (
  input  pci_pkg::cmd_t          cmd,
  input  logic signed [31:0]     p0_x,
  input  logic signed [31:0]     p0_y,
  input  logic signed [31:0]     p1_x,
  input  logic signed [31:0]     p1_y,
  input  logic signed [31:0]     p2_x,
  input  logic signed [31:0]     p2_y,
  input  logic [COORD_BITS-1:0]  current_x,
  input  logic [COORD_BITS-1:0]  current_y,
  input  logic [COORD_BITS-1:0]  start_x,
  input  logic [COORD_BITS-1:0]  start_y,
  input  logic                   have_point,
  input  logic                   have_edge,
  output logic [COORD_BITS-1:0]  current_x_next,
  output logic [COORD_BITS-1:0]  current_y_next,
  output logic [COORD_BITS-1:0]  start_x_next,
  output logic [COORD_BITS-1:0]  start_y_next,
  output logic                   have_point_next,
  output logic                   have_edge_next,
  output pci_pkg::ev_pair_t      events
);

  logic                  rel;
  logic [COORD_BITS-1:0] off_x, off_y;
  logic [COORD_BITS-1:0] q0_x, q0_y, q1_x, q1_y, q2_x, q2_y;
  logic [31:0]           o_cur_x, o_cur_y, o_st_x, o_st_y;
  logic [31:0]           o0_x, o0_y, o1_x, o1_y, o2_x, o2_y;

  // Sign-extend points to coordinate width and offset relative commands
  assign rel   = (cmd == pci_pkg::CMD_REL_MOVE) || (cmd == pci_pkg::CMD_REL_LINE) ||
                 (cmd == pci_pkg::CMD_REL_CURVE);
  assign off_x = rel ? current_x : '0;
  assign off_y = rel ? current_y : '0;
  assign q0_x  = COORD_BITS'(p0_x) + off_x;
  assign q0_y  = COORD_BITS'(p0_y) + off_y;
  assign q1_x  = COORD_BITS'(p1_x) + off_x;
  assign q1_y  = COORD_BITS'(p1_y) + off_y;
  assign q2_x  = COORD_BITS'(p2_x) + off_x;
  assign q2_y  = COORD_BITS'(p2_y) + off_y;

  // Output coordinates carry the low bits, zero-filled above the coordinate width
  assign o_cur_x = 32'(current_x);
  assign o_cur_y = 32'(current_y);
  assign o_st_x  = 32'(start_x);
  assign o_st_y  = 32'(start_y);
  assign o0_x    = 32'(q0_x);
  assign o0_y    = 32'(q0_y);
  assign o1_x    = 32'(q1_x);
  assign o1_y    = 32'(q1_y);
  assign o2_x    = 32'(q2_x);
  assign o2_y    = 32'(q2_y);

  // Build events and next state
  always_comb begin
    current_x_next  = current_x;
    current_y_next  = current_y;
    start_x_next    = start_x;
    start_y_next    = start_y;
    have_point_next = have_point;
    have_edge_next  = have_edge;
    events          = '0;
    case (cmd)
      pci_pkg::CMD_MOVE, pci_pkg::CMD_REL_MOVE: begin
        if (have_edge) begin
          events.count    = 2'd1;
          events.ev0.kind = pci_pkg::EV_CAP;
          events.ev0.last = 1'b1;
        end
        current_x_next  = q0_x;
        current_y_next  = q0_y;
        start_x_next    = q0_x;
        start_y_next    = q0_y;
        have_point_next = 1'b1;
        have_edge_next  = 1'b0;
      end
      pci_pkg::CMD_LINE, pci_pkg::CMD_REL_LINE: begin
        current_x_next = q0_x;
        current_y_next = q0_y;
        if (have_point) begin
          events.count    = 2'd1;
          events.ev0.kind = pci_pkg::EV_EDGE;
          events.ev0.a_x  = o_cur_x;
          events.ev0.a_y  = o_cur_y;
          events.ev0.b_x  = o0_x;
          events.ev0.b_y  = o0_y;
          events.ev0.last = 1'b1;
          have_edge_next  = 1'b1;
        end else begin
          start_x_next    = q0_x;
          start_y_next    = q0_y;
          have_point_next = 1'b1;
          have_edge_next  = 1'b0;
        end
      end
      pci_pkg::CMD_CURVE, pci_pkg::CMD_REL_CURVE: begin
        current_x_next = q2_x;
        current_y_next = q2_y;
        if (have_point) begin
          events.count    = 2'd1;
          events.ev0.kind = pci_pkg::EV_SPLINE;
          events.ev0.a_x  = o_cur_x;
          events.ev0.a_y  = o_cur_y;
          events.ev0.b_x  = o0_x;
          events.ev0.b_y  = o0_y;
          events.ev0.c_x  = o1_x;
          events.ev0.c_y  = o1_y;
          events.ev0.d_x  = o2_x;
          events.ev0.d_y  = o2_y;
          events.ev0.last = 1'b1;
          have_edge_next  = 1'b1;
        end else begin
          start_x_next    = q2_x;
          start_y_next    = q2_y;
          have_point_next = 1'b1;
          have_edge_next  = 1'b0;
        end
      end
      pci_pkg::CMD_CLOSE: begin
        if (have_edge) begin
          events.count    = 2'd2;
          events.ev0.kind = pci_pkg::EV_EDGE;
          events.ev0.a_x  = o_cur_x;
          events.ev0.a_y  = o_cur_y;
          events.ev0.b_x  = o_st_x;
          events.ev0.b_y  = o_st_y;
          events.ev0.last = 1'b0;
          events.ev1.kind = pci_pkg::EV_JOIN;
          events.ev1.last = 1'b1;
        end
        current_x_next  = '0;
        current_y_next  = '0;
        start_x_next    = '0;
        start_y_next    = '0;
        have_point_next = 1'b0;
        have_edge_next  = 1'b0;
      end
      pci_pkg::CMD_END_PATH: begin
        if (have_edge) begin
          events.count    = 2'd2;
          events.ev0.kind = pci_pkg::EV_CAP;
          events.ev0.last = 1'b0;
          events.ev1.kind = pci_pkg::EV_PATH;
          events.ev1.last = 1'b1;
        end else begin
          events.count    = 2'd1;
          events.ev0.kind = pci_pkg::EV_PATH;
          events.ev0.last = 1'b1;
        end
        current_x_next  = '0;
        current_y_next  = '0;
        start_x_next    = '0;
        start_y_next    = '0;
        have_point_next = 1'b0;
        have_edge_next  = 1'b0;
      end
      default: begin
        events = '0;
      end
    endcase
  end

endmodule

[rtl/pci_out.sv]
// Output stage: result register plus a hold slot for a second event.
module pci_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  pci_pkg::ev_pair_t  events,
  output pci_pkg::out_ctl_t  ctl,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [255:0]       m_tdata,  // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
  output logic [7:0]         m_tuser,  // event_kind[2:0], zero pad
  output logic               m_tlast   // last
);

  pci_pkg::event_t out_ev;
  pci_pkg::event_t pend_ev;
  logic            pend_valid;
  logic            slot_free;
  logic            take_pend;
  logic            take_new;

  // Output slot opens when empty or being drained this cycle
  assign slot_free    = !m_tvalid || m_tready;
  assign take_pend    = pend_valid && slot_free;
  assign take_new     = load && (events.count != 2'd0);
  assign ctl.can_load = !pend_valid && slot_free;
  assign ctl.pend_valid = pend_valid;

  // Advance control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
    end else if (take_pend) begin
      m_tvalid   <= 1'b1;
      pend_valid <= 1'b0;
    end else if (take_new) begin
      m_tvalid   <= 1'b1;
      pend_valid <= (events.count == 2'd2);
    end else if (m_tvalid && m_tready) begin
      m_tvalid   <= 1'b0;
    end
  end

  // Load event payloads
  always_ff @(posedge clk) begin
    if (take_pend) begin
      out_ev <= pend_ev;
    end else if (take_new) begin
      out_ev  <= events.ev0;
      pend_ev <= events.ev1;
    end
  end

  // Pack the result transfer
  assign m_tdata = {out_ev.d_y, out_ev.d_x, out_ev.c_y, out_ev.c_x,
                    out_ev.b_y, out_ev.b_x, out_ev.a_y, out_ev.a_x};
  assign m_tuser = {5'd0, out_ev.kind};
  assign m_tlast = out_ev.last;

endmodule
